### rtl/gnpd_pkg.sv
package gnpd_pkg;

	// fixed field widths
	localparam int CoordBits   = 24;
	localparam int IdxBits     = 12;
	localparam int RcBits      = 7;
	localparam int PosBits     = 2 * RcBits;
	localparam int TgtBits     = CoordBits + 1;
	localparam int DiffBits    = CoordBits + 2;
	localparam int DistBits    = 2 * DiffBits + 1;
	localparam int CfgIdxBits  = 3;
	localparam int CfgDataBits = CoordBits;
	localparam int StatusBits  = 2;

	// configuration register indexes
	localparam logic [CfgIdxBits-1:0] CfgRows    = 3'd0;
	localparam logic [CfgIdxBits-1:0] CfgCols    = 3'd1;
	localparam logic [CfgIdxBits-1:0] CfgOffX    = 3'd2;
	localparam logic [CfgIdxBits-1:0] CfgOffY    = 3'd3;
	localparam logic [CfgIdxBits-1:0] CfgOnePass = 3'd4;

	// item opcodes
	localparam logic OpLoad  = 1'b0;
	localparam logic OpQuery = 1'b1;

	// result status codes
	localparam logic [StatusBits-1:0] StOk        = 2'd0;
	localparam logic [StatusBits-1:0] StBadOrigin = 2'd1;
	localparam logic [StatusBits-1:0] StBadStart  = 2'd2;

	typedef struct packed {
		logic                        op;
		logic [IdxBits-1:0]          entry_index;
		logic signed [CoordBits-1:0] coord_x;
		logic signed [CoordBits-1:0] coord_y;
		logic [IdxBits-1:0]          origin_index;
		logic [IdxBits-1:0]          start_index;
	} in_item_t;

	typedef struct packed {
		logic [IdxBits-1:0]    result_index;
		logic [StatusBits-1:0] status;
	} out_item_t;

	// request to the squared distance unit
	typedef struct packed {
		logic                        start;
		logic signed [CoordBits-1:0] px;
		logic signed [CoordBits-1:0] py;
		logic signed [TgtBits-1:0]   tx;
		logic signed [TgtBits-1:0]   ty;
	} sqd_req_t;

	typedef struct packed {
		logic                done;
		logic [DistBits-1:0] dist_sq;
	} sqd_rsp_t;

endpackage

### rtl/grid_nearest_point_descent.sv
// greedy nearest-point descent over a grid of 2-d points held in on-chip memory
// input channel (in_valid / in_stall / in_item): op selects the item kind
//   load item: writes coord_x, coord_y into entry entry_index,
//   gives no result; entries at or beyond the store depth are dropped
//   query item: target = point[origin_index] + (offset_x, offset_y); starting
//   at start_index, tries left, right, up, down each pass and moves on any
//   strictly smaller squared distance; one result item per query
// output channel (out_valid / out_stall / out_item): result_index and status
// a query runs a setup (range check, start index divide, origin read, start
// distance), then one or more passes, and then loads the output register;
// each candidate takes a memory read, a unit start and the square x, square y
// and add phases of the shared squaring unit, a skipped one only advances the
// direction; the pass count depends on the data in multi-pass mode; a range
// error goes from the range check straight to the output register
// in_stall is high while a query is in flight, so one query runs at a time
// a finished result waits in the output register while out_stall is high;
// the next item is already taken meanwhile, a query then holds at its end
// reset clears the sequencer and the output valid, and sets the grid size
// registers to 64 x 64, offsets to zero and multi-pass mode; the point store
// is not cleared and must be loaded before queries read it
// configuration writes (cfg_wr_en, cfg_idx, cfg_wdata) only while idle
module grid_nearest_point_descent import gnpd_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_item,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_item,
	input  logic                   cfg_wr_en,
	input  logic [CfgIdxBits-1:0]  cfg_idx,
	input  logic [CfgDataBits-1:0] cfg_wdata
);

	// store depth follows the largest grid
	localparam int Depth    = MAX_ROWS * MAX_COLS;
	localparam int AddrBits = (Depth > 1) ? $clog2(Depth) : 1;

	// configuration registers
	logic [RcBits-1:0]           rows_q, cols_q;
	logic signed [CoordBits-1:0] offset_x_q, offset_y_q;
	logic                        one_pass_q;

	// clamped grid size
	logic [RcBits-1:0] m, n;

	logic                        st_wr_en, st_rd_en;
	logic [AddrBits-1:0]         st_wr_addr, st_rd_addr;
	logic signed [CoordBits-1:0] st_rd_x, st_rd_y;
	sqd_req_t                    sqd_req;
	sqd_rsp_t                    sqd_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q     <= RcBits'(64);
			cols_q     <= RcBits'(64);
			offset_x_q <= '0;
			offset_y_q <= '0;
			one_pass_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				CfgRows:    rows_q     <= cfg_wdata[RcBits-1:0];
				CfgCols:    cols_q     <= cfg_wdata[RcBits-1:0];
				CfgOffX:    offset_x_q <= cfg_wdata;
				CfgOffY:    offset_y_q <= cfg_wdata;
				CfgOnePass: one_pass_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// zero acts as one, anything above the store geometry is cut back
	always_comb begin
		if (rows_q == '0) begin
			m = RcBits'(1);
		end else if (32'(rows_q) > MAX_ROWS) begin
			m = RcBits'(MAX_ROWS);
		end else begin
			m = rows_q;
		end
		if (cols_q == '0) begin
			n = RcBits'(1);
		end else if (32'(cols_q) > MAX_COLS) begin
			n = RcBits'(MAX_COLS);
		end else begin
			n = cols_q;
		end
	end

	gnpd_store #(
		.Depth    (Depth),
		.AddrBits (AddrBits)
	) u_store (
		.clk     (clk),
		.wr_en   (st_wr_en),
		.wr_addr (st_wr_addr),
		.wr_x    (in_item.coord_x),
		.wr_y    (in_item.coord_y),
		.rd_en   (st_rd_en),
		.rd_addr (st_rd_addr),
		.rd_x    (st_rd_x),
		.rd_y    (st_rd_y)
	);

	// shared squaring unit: exact squared distance
	gnpd_sqdist u_sqdist (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sqd_req),
		.rsp    (sqd_rsp)
	);

	// sequencer: range checks, start index divide, passes, output register
	gnpd_ctrl #(
		.Depth    (Depth),
		.AddrBits (AddrBits)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item),
		.m          (m),
		.n          (n),
		.offset_x   (offset_x_q),
		.offset_y   (offset_y_q),
		.one_pass   (one_pass_q),
		.st_wr_en   (st_wr_en),
		.st_wr_addr (st_wr_addr),
		.st_rd_en   (st_rd_en),
		.st_rd_addr (st_rd_addr),
		.st_rd_x    (st_rd_x),
		.st_rd_y    (st_rd_y),
		.sqd_req    (sqd_req),
		.sqd_rsp    (sqd_rsp)
	);

`ifndef SYNTHESIS
	// an error result always reports entry zero
	a_err_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status != StOk) |-> (out_item.result_index == '0))
		else $error("error result with nonzero index");

	// the store is written only by an accepted load item
	a_wr_only_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		st_wr_en |-> (in_valid && !in_stall && (in_item.op == OpLoad)))
		else $error("store write without a load item");

	// distance work happens only while a query holds the input side
	a_dist_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sqd_req.start |-> in_stall)
		else $error("distance unit started while idle");
`endif

endmodule

### rtl/gnpd_store.sv
module gnpd_store import gnpd_pkg::*; #(
	parameter int Depth = 4096,
	parameter int AddrBits = 12
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AddrBits-1:0]         wr_addr,
	input  logic signed [CoordBits-1:0] wr_x,
	input  logic signed [CoordBits-1:0] wr_y,
	input  logic                        rd_en,
	input  logic [AddrBits-1:0]         rd_addr,
	output logic signed [CoordBits-1:0] rd_x,
	output logic signed [CoordBits-1:0] rd_y
);

	// x in the upper half, y in the lower half
	logic [2*CoordBits-1:0] mem_q [Depth];
	logic [2*CoordBits-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= {wr_x, wr_y};
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_x = rd_data_q[2*CoordBits-1:CoordBits];
	assign rd_y = rd_data_q[CoordBits-1:0];

endmodule

### rtl/gnpd_sqdist.sv
module gnpd_sqdist import gnpd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  sqd_req_t req,
	output sqd_rsp_t rsp
);

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_SQX  = 4'b0010,
		PH_SQY  = 4'b0100,
		PH_ADD  = 4'b1000
	} phase_t;

	phase_t phase_q;
	logic   done_q;

	logic signed [DiffBits-1:0] dx, dy;
	logic [DiffBits-1:0]        mag_x_q, mag_y_q, mul_op;
	logic [2*DiffBits-1:0]      prod_q, acc_q;
	logic [DistBits-1:0]        dist_q;

	// exact differences, then magnitudes
	assign dx = {req.tx[TgtBits-1], req.tx} - {{2{req.px[CoordBits-1]}}, req.px};
	assign dy = {req.ty[TgtBits-1], req.ty} - {{2{req.py[CoordBits-1]}}, req.py};

	// the one multiplier, shared between the two axes
	assign mul_op = (phase_q == PH_SQX) ? mag_x_q : mag_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (phase_q == PH_ADD);
			case (phase_q)
				PH_IDLE: if (req.start) phase_q <= PH_SQX;
				PH_SQX:  phase_q <= PH_SQY;
				PH_SQY:  phase_q <= PH_ADD;
				PH_ADD:  phase_q <= PH_IDLE;
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && req.start) begin
			mag_x_q <= dx[DiffBits-1] ? DiffBits'(-dx) : DiffBits'(dx);
			mag_y_q <= dy[DiffBits-1] ? DiffBits'(-dy) : DiffBits'(dy);
		end
		if (phase_q == PH_SQX || phase_q == PH_SQY) begin
			prod_q <= mul_op * mul_op;
		end
		if (phase_q == PH_SQY) begin
			acc_q <= prod_q;
		end
		if (phase_q == PH_ADD) begin
			dist_q <= {1'b0, acc_q} + {1'b0, prod_q};
		end
	end

	assign rsp.done    = done_q;
	assign rsp.dist_sq = dist_q;

endmodule

### rtl/gnpd_ctrl.sv
module gnpd_ctrl import gnpd_pkg::*; #(
	parameter int Depth = 4096,
	parameter int AddrBits = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  in_item_t                    in_item,
	output logic                        out_valid,
	input  logic                        out_stall,
	output out_item_t                   out_item,
	input  logic [RcBits-1:0]           m,
	input  logic [RcBits-1:0]           n,
	input  logic signed [CoordBits-1:0] offset_x,
	input  logic signed [CoordBits-1:0] offset_y,
	input  logic                        one_pass,
	output logic                        st_wr_en,
	output logic [AddrBits-1:0]         st_wr_addr,
	output logic                        st_rd_en,
	output logic [AddrBits-1:0]         st_rd_addr,
	input  logic signed [CoordBits-1:0] st_rd_x,
	input  logic signed [CoordBits-1:0] st_rd_y,
	output sqd_req_t                    sqd_req,
	input  sqd_rsp_t                    sqd_rsp
);

	typedef enum logic [10:0] {
		S_IDLE    = 11'b00000000001,
		S_CHECK   = 11'b00000000010,
		S_DIV     = 11'b00000000100,
		S_ORG_RD  = 11'b00000001000,
		S_ORG_LAT = 11'b00000010000,
		S_PT_RD   = 11'b00000100000,
		S_PT_GO   = 11'b00001000000,
		S_PT_WAIT = 11'b00010000000,
		S_PASS    = 11'b00100000000,
		S_NEXT    = 11'b01000000000,
		S_DONE    = 11'b10000000000
	} state_t;

	localparam logic [1:0] DirLeft  = 2'd0;
	localparam logic [1:0] DirRight = 2'd1;
	localparam logic [1:0] DirUp    = 2'd2;
	localparam logic [1:0] DirDown  = 2'd3;

	state_t state_q;
	logic   out_valid_q;
	out_item_t out_q, res_q;

	logic [IdxBits-1:0]        o_q, dvd_q;
	logic [RcBits-1:0]         rem_q, col_q, row_q, cand_col_q, cand_row_q;
	logic [3:0]                cnt_q;
	logic [PosBits-1:0]        p_q, mn_q, cand_q;
	logic [DistBits-1:0]       d_q;
	logic                      first_q, improved_q;
	logic [3:0]                ok_q;
	logic [2:0]                k_q;
	logic signed [TgtBits-1:0] tx_q, ty_q;

	logic                accept, res_load;
	logic [RcBits:0]     trial;
	logic                trial_ge;
	logic [RcBits-1:0]   rem_next;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign res_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// load items go straight to the store
	assign st_wr_en   = accept && (in_item.op == OpLoad) && (32'(in_item.entry_index) < Depth);
	assign st_wr_addr = AddrBits'(in_item.entry_index);

	assign st_rd_en   = (state_q == S_ORG_RD) || (state_q == S_PT_RD);
	assign st_rd_addr = (state_q == S_ORG_RD) ? AddrBits'(o_q) : AddrBits'(cand_q);

	assign sqd_req.start = (state_q == S_PT_GO);
	assign sqd_req.px    = st_rd_x;
	assign sqd_req.py    = st_rd_y;
	assign sqd_req.tx    = tx_q;
	assign sqd_req.ty    = ty_q;

	// restoring division step: one quotient bit per cycle
	assign trial    = {rem_q, dvd_q[IdxBits-1]};
	assign trial_ge = trial >= {1'b0, m};
	assign rem_next = trial_ge ? RcBits'(trial - {1'b0, m}) : trial[RcBits-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (out_valid_q && out_stall) || res_load;
			case (state_q)
				S_IDLE: begin
					if (accept && in_item.op == OpQuery) state_q <= S_CHECK;
				end
				S_CHECK: begin
					if ({2'b0, o_q} >= mn_q || {2'b0, dvd_q} >= mn_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == 4'(IdxBits - 1)) state_q <= S_ORG_RD;
				end
				S_ORG_RD:  state_q <= S_ORG_LAT;
				S_ORG_LAT: state_q <= S_PT_RD;
				S_PT_RD:   state_q <= S_PT_GO;
				S_PT_GO:   state_q <= S_PT_WAIT;
				S_PT_WAIT: begin
					if (sqd_rsp.done) state_q <= first_q ? S_PASS : S_NEXT;
				end
				S_PASS: state_q <= S_NEXT;
				S_NEXT: begin
					if (k_q[2]) begin
						state_q <= (improved_q && !one_pass) ? S_PASS : S_DONE;
					end else if (ok_q[k_q[1:0]]) begin
						state_q <= S_PT_RD;
					end
				end
				S_DONE: begin
					if (res_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) out_q <= res_q;
		case (state_q)
			S_IDLE: begin
				o_q   <= in_item.origin_index;
				dvd_q <= in_item.start_index;
				p_q   <= PosBits'(in_item.start_index);
				rem_q <= '0;
				cnt_q <= '0;
				mn_q  <= {{RcBits{1'b0}}, m} * {{RcBits{1'b0}}, n};
			end
			S_CHECK: begin
				res_q.result_index <= '0;
				if ({2'b0, o_q} >= mn_q) begin
					res_q.status <= StBadOrigin;
				end else begin
					res_q.status <= StBadStart;
				end
			end
			S_DIV: begin
				rem_q <= rem_next;
				dvd_q <= {dvd_q[IdxBits-2:0], trial_ge};
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(IdxBits - 1)) begin
					col_q      <= rem_next;
					row_q      <= RcBits'({dvd_q[IdxBits-2:0], trial_ge});
					cand_q     <= p_q;
					first_q    <= 1'b1;
				end
			end
			S_ORG_LAT: begin
				tx_q <= {st_rd_x[CoordBits-1], st_rd_x} + {offset_x[CoordBits-1], offset_x};
				ty_q <= {st_rd_y[CoordBits-1], st_rd_y} + {offset_y[CoordBits-1], offset_y};
			end
			S_PT_WAIT: begin
				if (sqd_rsp.done) begin
					if (first_q) begin
						d_q     <= sqd_rsp.dist_sq;
						first_q <= 1'b0;
					end else begin
						k_q <= k_q + 3'd1;
						if (sqd_rsp.dist_sq < d_q) begin
							d_q        <= sqd_rsp.dist_sq;
							p_q        <= cand_q;
							col_q      <= cand_col_q;
							row_q      <= cand_row_q;
							improved_q <= 1'b1;
						end
					end
				end
			end
			S_PASS: begin
				// neighbor bounds are frozen at the start of the pass
				ok_q[DirLeft]  <= (col_q != '0);
				ok_q[DirRight] <= ({1'b0, col_q} + 8'd1) < {1'b0, m};
				ok_q[DirUp]    <= (row_q != '0);
				ok_q[DirDown]  <= ({1'b0, row_q} + 8'd1) < {1'b0, n};
				improved_q     <= 1'b0;
				k_q            <= '0;
			end
			S_NEXT: begin
				if (k_q[2]) begin
					res_q.result_index <= IdxBits'(p_q);
					res_q.status       <= StOk;
				end else if (ok_q[k_q[1:0]]) begin
					cand_col_q <= col_q;
					cand_row_q <= row_q;
					case (k_q[1:0])
						DirLeft: begin
							cand_q     <= p_q - PosBits'(1);
							cand_col_q <= col_q - RcBits'(1);
						end
						DirRight: begin
							cand_q     <= p_q + PosBits'(1);
							cand_col_q <= col_q + RcBits'(1);
						end
						DirUp: begin
							cand_q     <= p_q - {{RcBits{1'b0}}, m};
							cand_row_q <= row_q - RcBits'(1);
						end
						DirDown: begin
							cand_q     <= p_q + {{RcBits{1'b0}}, m};
							cand_row_q <= row_q + RcBits'(1);
						end
						default: cand_q <= p_q;
					endcase
				end else begin
					k_q <= k_q + 3'd1;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

### dv/grid_nearest_point_descent_tb.sv
module grid_nearest_point_descent_tb;
	import gnpd_pkg::*;

	localparam int GridRows   = 64;
	localparam int GridCols   = 64;
	localparam int StoreDepth = GridRows * GridCols;
	localparam int PlanLen    = 21;

	// how the target offset of a phase is chosen
	typedef enum {OffNear, OffLowHigh, OffHighLow, OffAny} offset_mode_t;

	// one row of the directed table: the item, and a hand-written answer where one is given
	typedef struct packed {
		in_item_t  item;
		logic      typed;
		out_item_t want;
	} plan_row_t;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	in_item_t               in_item   = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	out_item_t              out_item;
	logic                   cfg_wr_en = 1'b0;
	logic [CfgIdxBits-1:0]  cfg_idx   = '0;
	logic [CfgDataBits-1:0] cfg_wdata = '0;

	// shadow copy of the point store, with a mark per entry once it holds a point
	logic signed [CoordBits-1:0] grid_x [StoreDepth];
	logic signed [CoordBits-1:0] grid_y [StoreDepth];
	bit                          grid_loaded [StoreDepth];

	// shadow copy of the registers, at their reset values
	logic [RcBits-1:0]           grid_rows   = 7'd64;
	logic [RcBits-1:0]           grid_cols   = 7'd64;
	logic signed [CoordBits-1:0] shift_x     = '0;
	logic signed [CoordBits-1:0] shift_y     = '0;
	bit                          single_pass = 1'b0;

	out_item_t awaited_descents [$];
	plan_row_t plan [PlanLen];
	int        mismatches    = 0;
	int        send_calm     = 0;
	int        recv_calm     = 0;
	int        results_taken = 0;

	grid_nearest_point_descent #(
		.MAX_ROWS(GridRows),
		.MAX_COLS(GridCols)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.cfg_wr_en(cfg_wr_en),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// grid extent as the block sees it: zero acts as one, large values stop at the maximum
	function automatic int clamp_dim(int v, int lim);
		if (v < 1)
			return 1;
		return (v > lim) ? lim : v;
	endfunction

	// exact squared distance from a stored point to the target
	function automatic longint sq_dist(int e, longint tx, longint ty);
		longint dx, dy;
		dx = longint'(grid_x[e]) - tx;
		dy = longint'(grid_y[e]) - ty;
		return dx * dx + dy * dy;
	endfunction

	// greedy descent toward point[origin] + offset, starting at the start entry
	function automatic out_item_t descend_from(logic [IdxBits-1:0] origin_idx,
	                                           logic [IdxBits-1:0] start_idx);
		int        m, n, mn, pos, col, row, cand, k;
		bit        can_go, moved;
		longint    tx, ty, best, d;
		out_item_t r;
		m = clamp_dim(grid_rows, GridRows);
		n = clamp_dim(grid_cols, GridCols);
		mn = m * n;
		r = '0;
		r.status = StOk;
		// origin is checked before start
		if (int'(origin_idx) >= mn) begin
			r.status = StBadOrigin;
			return r;
		end
		if (int'(start_idx) >= mn) begin
			r.status = StBadStart;
			return r;
		end
		tx = longint'(grid_x[origin_idx]) + longint'(shift_x);
		ty = longint'(grid_y[origin_idx]) + longint'(shift_y);
		pos = start_idx;
		best = sq_dist(pos, tx, ty);
		do begin
			// bounds come from the position at the start of the pass,
			// each candidate from wherever the walk stands now
			col = pos % m;
			row = pos / m;
			moved = 1'b0;
			for (k = 0; k < 4; k++) begin
				case (k)
					0: begin
						can_go = col > 0;
						cand = pos - 1;
					end
					1: begin
						can_go = col + 1 < m;
						cand = pos + 1;
					end
					2: begin
						can_go = row > 0;
						cand = pos - m;
					end
					default: begin
						can_go = row + 1 < n;
						cand = pos + m;
					end
				endcase
				if (can_go && cand >= 0 && cand < mn) begin
					d = sq_dist(cand, tx, ty);
					// only a strictly closer neighbour is taken
					if (d < best) begin
						pos = cand;
						best = d;
						moved = 1'b1;
					end
				end
			end
		end while (moved && !single_pass);
		r.result_index = IdxBits'(pos);
		return r;
	endfunction

	// wait per item, with the odd stretch of back-to-back items
	function automatic int pick_wait(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0)
			calm_left = $urandom_range(10, 40);
		return $urandom_range(0, 18);
	endfunction

	function automatic plan_row_t load_row(int e, int x, int y);
		plan_row_t r;
		r = '0;
		r.item.op = OpLoad;
		r.item.entry_index = IdxBits'(e);
		r.item.coord_x = CoordBits'(x);
		r.item.coord_y = CoordBits'(y);
		return r;
	endfunction

	function automatic plan_row_t query_row(int o, int s);
		plan_row_t r;
		r = '0;
		r.item.op = OpQuery;
		r.item.origin_index = IdxBits'(o);
		r.item.start_index = IdxBits'(s);
		return r;
	endfunction

	// range errors have an answer that needs no descent
	function automatic plan_row_t fault_row(int o, int s, logic [StatusBits-1:0] st);
		plan_row_t r;
		r = query_row(o, s);
		r.typed = 1'b1;
		r.want.result_index = '0;
		r.want.status = st;
		return r;
	endfunction

	// load item: either a point of a tilted lattice, so descents run long, or anywhere
	function automatic in_item_t make_load(int e, int m, int pitch_x, int pitch_y,
	                                       bit scatter);
		in_item_t it;
		it.op = OpLoad;
		it.entry_index = IdxBits'(e);
		it.origin_index = IdxBits'($urandom);
		it.start_index = IdxBits'($urandom);
		if (scatter) begin
			it.coord_x = CoordBits'($urandom);
			it.coord_y = CoordBits'($urandom);
		end else begin
			it.coord_x = CoordBits'((e % m) * pitch_x + int'($urandom_range(0, 255)));
			it.coord_y = CoordBits'((e / m) * pitch_y + int'($urandom_range(0, 255)));
		end
		return it;
	endfunction

	// offer one item and, once taken, update the shadow store or queue the answer
	task automatic offer(in_item_t it, logic typed, out_item_t want);
		int gap;
		gap = pick_wait(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		if (it.op == OpLoad) begin
			grid_x[it.entry_index] = it.coord_x;
			grid_y[it.entry_index] = it.coord_y;
			grid_loaded[it.entry_index] = 1'b1;
		end else begin
			awaited_descents.push_back(typed ? want : descend_from(it.origin_index,
			                                                       it.start_index));
		end
	endtask

	// stop offering, let every answer come back, then give the block time to go idle
	task automatic drain_and_pause(int pause);
		in_valid <= 1'b0;
		while (awaited_descents.size() != 0) @(posedge clk);
		repeat (pause) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			CfgRows:    grid_rows = val[RcBits-1:0];
			CfgCols:    grid_cols = val[RcBits-1:0];
			CfgOffX:    shift_x = val;
			CfgOffY:    shift_y = val;
			CfgOnePass: single_pass = val[0];
			default: ;
		endcase
	endtask

	// one setting of the registers, a lattice laid over the grid, then random items
	task automatic run_phase(int rows, int cols, bit one_pass, offset_mode_t off_mode,
	                         int count);
		int                          m, n, mn, pitch_x, pitch_y, i, e, kind;
		logic signed [CoordBits-1:0] off_x, off_y;
		in_item_t                    it;
		m = clamp_dim(rows, GridRows);
		n = clamp_dim(cols, GridCols);
		mn = m * n;
		pitch_x = $urandom_range(1, 60000);
		pitch_y = $urandom_range(1, 60000);
		if ($urandom_range(0, 1))
			pitch_x = -pitch_x;
		if ($urandom_range(0, 1))
			pitch_y = -pitch_y;
		case (off_mode)
			OffLowHigh: begin
				off_x = -24'sd8388608;
				off_y = 24'sd8388607;
			end
			OffHighLow: begin
				off_x = 24'sd8388607;
				off_y = -24'sd8388608;
			end
			OffAny: begin
				off_x = CoordBits'($urandom);
				off_y = CoordBits'($urandom);
			end
			default: begin
				// a few lattice steps away, so the walk has somewhere to go
				off_x = CoordBits'((int'($urandom_range(0, 2 * m)) - m) * pitch_x);
				off_y = CoordBits'((int'($urandom_range(0, 2 * n)) - n) * pitch_y);
			end
		endcase

		drain_and_pause(20);
		write_reg(CfgRows, CfgDataBits'(rows));
		write_reg(CfgCols, CfgDataBits'(cols));
		write_reg(CfgOffX, off_x);
		write_reg(CfgOffY, off_y);
		write_reg(CfgOnePass, one_pass);
		cfg_wr_en <= 1'b0;

		// small grids (up to 1024 entries) get a fresh lattice, larger ones only their missing entries
		for (e = 0; e < mn; e++)
			if (mn <= 1024 || !grid_loaded[e])
				offer(make_load(e, m, pitch_x, pitch_y, 1'b0), 1'b0, '0);

		for (i = 0; i < count; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				e = ($urandom_range(0, 6) != 0) ? $urandom_range(0, mn - 1)
				                                : $urandom_range(0, StoreDepth - 1);
				offer(make_load(e, m, pitch_x, pitch_y, $urandom_range(0, 3) == 0),
				      1'b0, '0);
			end else begin
				it.op = OpQuery;
				it.entry_index = IdxBits'($urandom);
				it.coord_x = CoordBits'($urandom);
				it.coord_y = CoordBits'($urandom);
				it.origin_index = IdxBits'($urandom_range(0, mn - 1));
				it.start_index = IdxBits'($urandom_range(0, mn - 1));
				// out-of-range indexes only exist below the full grid
				if (mn < StoreDepth && kind < 38) begin
					it.origin_index = IdxBits'($urandom_range(mn, StoreDepth - 1));
					it.start_index = IdxBits'($urandom);
				end else if (mn < StoreDepth && kind < 45) begin
					it.start_index = IdxBits'($urandom_range(mn, StoreDepth - 1));
				end
				offer(it, 1'b0, '0);
			end
		end
	endtask

	// result side: random stalls, two long hold-offs so the block backs up
	initial begin : result_sink
		int        hold;
		out_item_t want;
		wait (arst_n === 1'b1);
		forever begin
			hold = pick_wait(recv_calm);
			if (results_taken == 100 || results_taken == 300)
				hold = 500;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
			results_taken++;
			if (awaited_descents.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result: expected none, actual index %0d status %0d",
				         $time, out_item.result_index, out_item.status);
			end else begin
				want = awaited_descents.pop_front();
				if (out_item.result_index !== want.result_index) begin
					mismatches++;
					$display("%0t: result_index: expected %0d, actual %0d",
					         $time, want.result_index, out_item.result_index);
				end
				if (out_item.status !== want.status) begin
					mismatches++;
					$display("%0t: status: expected %0d, actual %0d",
					         $time, want.status, out_item.status);
				end
			end
		end
	end

	initial begin : stimulus
		int i;
		// 3 x 2 grid: corner coordinates, range errors, short descents
		plan = '{
			load_row(0, -8388608, -8388608),
			load_row(1, 8388607, 8388607),
			load_row(2, 0, 0),
			load_row(3, 8388607, -8388608),
			load_row(4, -8388608, 8388607),
			load_row(5, 100, -100),
			load_row(4095, 12345, -12345),
			fault_row(6, 0, StBadOrigin),
			fault_row(4095, 4095, StBadOrigin),
			fault_row(0, 6, StBadStart),
			fault_row(5, 4095, StBadStart),
			query_row(0, 0),
			query_row(1, 0),
			query_row(0, 1),
			query_row(3, 5),
			query_row(4, 2),
			query_row(2, 5),
			load_row(2, -8388608, 8388607),
			query_row(4, 0),
			query_row(5, 5),
			query_row(1, 4)
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// offsets and pass mode stay at their reset values for the table
		write_reg(CfgRows, 3);
		write_reg(CfgCols, 2);
		cfg_wr_en <= 1'b0;
		for (i = 0; i < PlanLen; i++)
			offer(plan[i].item, plan[i].typed, plan[i].want);

		// zero sizes act as one, 127 stops at 64
		run_phase(0, 0, 1'b0, OffNear, 40);
		run_phase(8, 8, 1'b0, OffNear, 70);
		run_phase(127, 3, 1'b0, OffLowHigh, 70);
		run_phase(64, 2, 1'b1, OffNear, 70);
		run_phase(1, 64, 1'b0, OffHighLow, 70);
		run_phase(64, 1, 1'b1, OffNear, 70);
		run_phase(13, 5, 1'b1, OffAny, 70);
		run_phase(12, 10, 1'b0, OffNear, 70);
		run_phase(2, 127, 1'b1, OffLowHigh, 60);

		drain_and_pause(200);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog against a hung handshake
	initial begin
		#100000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

### files.f
rtl/gnpd_pkg.sv
rtl/gnpd_store.sv
rtl/gnpd_sqdist.sv
rtl/gnpd_ctrl.sv
rtl/grid_nearest_point_descent.sv
dv/grid_nearest_point_descent_tb.sv
